/* src/lmfb_pkg.sv */
// Shared types and constants for the LED matrix frame buffer.
// No dependencies; used by led_matrix_frame_buffer_unit.
package lmfb_pkg;

  localparam int NUM_CHIPS_DEF    = 4;
  localparam int CHIPS_ACROSS_DEF = 2;
  localparam int CHIP_SIDE        = 8;
  localparam int ROW_W            = 3;

  localparam logic [1:0] CMD_SET_PIXEL = 2'd0;
  localparam logic [1:0] CMD_CLEAR     = 2'd1;
  localparam logic [1:0] CMD_REFRESH   = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    logic       pixel_on;
  } in_t;

  typedef struct packed {
    logic [3:0] digit_register;
    logic [7:0] row_data;
    logic [3:0] chain_slot;
    logic       end_of_row_group;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PIXEL = 3'b010,
    ST_SCAN  = 3'b100
  } state_t;

endpackage

/* src/led_matrix_frame_buffer_unit.sv */
// Top level of the LED matrix frame buffer: pixel store plus row scan-out.
// Depends on lmfb_pkg and lmfb_ram.
//
// Usage
//   A request is taken at a clock edge where start is high and busy is low.
//   cmd set pixel: maps (pos_x, pos_y) to chip, row and bit and sets or
//     clears that bit; off-grid pixels and unused cmd codes are dropped.
//     A pixel request holds busy for one cycle (read, then modify-write),
//     so the next request is taken only once the write is done.
//   cmd refresh: emits NUM_CHIPS*8 driver commands, one per cycle, row 0
//     first and, within a row, the last chip in the chain first. The first
//     result follows the state and store read registers; busy stays high
//     until the last entry is read through the store's single read port.
//   cmd clear: zeroes the store at once, then refreshes as above.
//   Results: result_strobe is high for exactly one cycle per command, with
//   the command on result; the receiver cannot stall, so the sequence runs
//   at full rate. A new request may be taken in the cycle the final result
//   is shown.
//   Reset (rst, synchronous) returns the sequencer to idle and clears the
//   per-entry valid flags, so the whole store reads as zero at once; no
//   clearing pass is needed.
module led_matrix_frame_buffer_unit #(
  parameter int NUM_CHIPS    = lmfb_pkg::NUM_CHIPS_DEF,
  parameter int CHIPS_ACROSS = lmfb_pkg::CHIPS_ACROSS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lmfb_pkg::in_t request,
  output lmfb_pkg::out_t result,
  output logic          result_strobe
);

  localparam int CHIP_W = $clog2(NUM_CHIPS);
  localparam int ADDR_W = CHIP_W + lmfb_pkg::ROW_W;
  localparam int DEPTH  = NUM_CHIPS * lmfb_pkg::CHIP_SIDE;
  localparam int GRID_W = CHIPS_ACROSS * lmfb_pkg::CHIP_SIDE;
  localparam int GRID_H = (NUM_CHIPS / CHIPS_ACROSS) * lmfb_pkg::CHIP_SIDE;
  localparam logic [CHIP_W-1:0] LAST_SLOT = CHIP_W'(NUM_CHIPS - 1);
  localparam logic [lmfb_pkg::ROW_W-1:0] LAST_ROW = '1;

  lmfb_pkg::state_t state, state_next;

  // Store: one byte per chip row, entry chip*8 + row. Valid flags give
  // zero for entries not written since reset or the last clear.
  logic [DEPTH-1:0]  valid;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Pixel read-modify-write stage.
  logic [ADDR_W-1:0]          pix_addr;
  logic [lmfb_pkg::ROW_W-1:0] pix_bit;
  logic                       pix_on;
  logic                       pix_hit;

  // Scan counters and the read-to-output stage.
  logic [lmfb_pkg::ROW_W-1:0] scan_row;
  logic [CHIP_W-1:0]          scan_slot;
  logic                       pend;
  logic                       pend_hit;
  logic [lmfb_pkg::ROW_W-1:0] pend_row;
  logic [CHIP_W-1:0]          pend_slot;

  logic              accept;
  logic              in_grid;
  logic [4:0]        chip_full;
  logic [ADDR_W-1:0] req_addr;
  logic [ADDR_W-1:0] scan_addr;
  logic [CHIP_W-1:0] scan_chip;
  logic [7:0]        old_byte;
  logic [7:0]        bit_mask;
  logic              scan_end;

  assign busy   = (state != lmfb_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Pixel address decode: chip = (y/8)*across + x/8, row = y%8.
  // Grid height can reach 128, so the bounds are compared at 8 bits.
  assign in_grid   = ({3'b000, request.pos_x} < 8'(GRID_W)) &&
                     ({3'b000, request.pos_y} < 8'(GRID_H));
  assign chip_full = {3'b000, request.pos_y[4:3]} * 5'(CHIPS_ACROSS) +
                     {3'b000, request.pos_x[4:3]};
  assign req_addr  = {chip_full[CHIP_W-1:0], request.pos_y[2:0]};

  // Scan order: slot 0 is the last chip in the chain.
  assign scan_chip = LAST_SLOT - scan_slot;
  assign scan_addr = {scan_chip, scan_row};
  assign scan_end  = (scan_slot == LAST_SLOT) && (scan_row == LAST_ROW);

  assign ram_raddr = (state == lmfb_pkg::ST_SCAN) ? scan_addr : req_addr;

  assign old_byte  = pix_hit ? ram_rdata : 8'h00;
  assign bit_mask  = 8'h01 << pix_bit;
  assign ram_we    = (state == lmfb_pkg::ST_PIXEL);
  assign ram_waddr = pix_addr;
  assign ram_wdata = pix_on ? (old_byte | bit_mask) : (old_byte & ~bit_mask);

  lmfb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      lmfb_pkg::ST_IDLE: begin
        if (accept) begin
          if (request.cmd == lmfb_pkg::CMD_SET_PIXEL && in_grid) begin
            state_next = lmfb_pkg::ST_PIXEL;
          end else if (request.cmd == lmfb_pkg::CMD_CLEAR ||
                       request.cmd == lmfb_pkg::CMD_REFRESH) begin
            state_next = lmfb_pkg::ST_SCAN;
          end
        end
      end
      lmfb_pkg::ST_PIXEL: begin
        state_next = lmfb_pkg::ST_IDLE;
      end
      lmfb_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = lmfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lmfb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lmfb_pkg::ST_IDLE;
      valid     <= '0;
      pend      <= 1'b0;
      scan_row  <= '0;
      scan_slot <= '0;
    end else begin
      state <= state_next;
      pend  <= (state == lmfb_pkg::ST_SCAN);
      if (accept && request.cmd == lmfb_pkg::CMD_CLEAR) begin
        valid <= '0;
      end else if (state == lmfb_pkg::ST_PIXEL) begin
        valid[pix_addr] <= 1'b1;
      end
      if (state == lmfb_pkg::ST_SCAN) begin
        if (scan_slot == LAST_SLOT) begin
          scan_slot <= '0;
          scan_row  <= scan_row + 1'b1;
        end else begin
          scan_slot <= scan_slot + 1'b1;
        end
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_addr <= req_addr;
      pix_bit  <= request.pos_x[2:0];
      pix_on   <= request.pixel_on;
      pix_hit  <= valid[req_addr];
    end
    pend_hit  <= valid[scan_addr];
    pend_row  <= scan_row;
    pend_slot <= scan_slot;
  end

  // Output stage: read data arrives in the cycle after the scan address.
  assign result_strobe           = pend;
  assign result.digit_register   = {1'b0, pend_row} + 4'd1;
  assign result.row_data         = pend_hit ? ram_rdata : 8'h00;
  assign result.chain_slot       = 4'(pend_slot);
  assign result.end_of_row_group = (pend_slot == LAST_SLOT);
  assign result.last             = (pend_slot == LAST_SLOT) && (pend_row == LAST_ROW);

endmodule

/* src/lmfb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lmfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
